// ===== rtl/core/acf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_pkg: shared types and codes of the application channel state machine
// Channel states, event opcodes, action, timer and status codes, and the
// function codes that steer a send.
// ----------------------------------------------------------------------------
package acf_pkg;

   // Field widths that do not vary
   localparam int OPCODE_W = 3;
   localparam int FUNC_W   = 8;
   localparam int LIMIT_W  = 8;
   localparam int ACTION_W = 3;
   localparam int TIMER_W  = 2;
   localparam int STATUS_W = 4;
   localparam int STATE_W  = 3;

   typedef enum logic [STATE_W-1:0] {
      ST_IDLE       = 3'd0,
      ST_SEND       = 3'd1,
      ST_SEND_CONF  = 3'd2,
      ST_SEND_EXP   = 3'd3,
      ST_SEND_CANC  = 3'd4,
      ST_WAIT_CONF  = 3'd5,
      ST_WAIT_FIRST = 3'd6,
      ST_WAIT_FINAL = 3'd7
   } chan_state_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SEND     = 3'd0,
      OP_CANCEL   = 3'd1,
      OP_SEND_OK  = 3'd2,
      OP_SEND_ERR = 3'd3,
      OP_CONFIRM  = 3'd4,
      OP_RESPONSE = 3'd5,
      OP_TIMEOUT  = 3'd6,
      OP_SET_SEQ  = 3'd7
   } opcode_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE    = 3'd0,
      ACT_QUEUE   = 3'd1,
      ACT_RESEND  = 3'd2,
      ACT_SUCCESS = 3'd3,
      ACT_FAIL    = 3'd4,
      ACT_FINAL   = 3'd5,
      ACT_PARTIAL = 3'd6
   } action_type;

   typedef enum logic [TIMER_W-1:0] {
      TMR_NONE   = 2'd0,
      TMR_START  = 2'd1,
      TMR_CANCEL = 2'd2
   } timer_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK          = 4'd0,
      STS_INVALID     = 4'd1,
      STS_BAD_SEQ     = 4'd2,
      STS_BAD_FIR     = 4'd3,
      STS_UNEXP_CONF  = 4'd4,
      STS_MANUAL_CONF = 4'd5,
      STS_NO_REQ      = 4'd6,
      STS_CON_IGN     = 4'd7,
      STS_TIMEOUT     = 4'd8
   } status_type;

   // Application function codes
   localparam logic [FUNC_W-1:0] FC_CONFIRM     = 8'd0;
   localparam logic [FUNC_W-1:0] FC_DIR_OP_NACK = 8'd6;
   localparam logic [FUNC_W-1:0] FC_RESPONSE    = 8'd129;
   localparam logic [FUNC_W-1:0] FC_UNSOLICITED = 8'd130;

endpackage

// ===== rtl/core/acf_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_in_reg: request input register
// Captures one request and holds it until the transition logic consumes it;
// refills in the same cycle that the held request advances.
// ----------------------------------------------------------------------------
module acf_in_reg #(
   parameter int SEQ_BITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [acf_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [acf_pkg::FUNC_W-1:0]      req_function_code,
   input  logic                            req_fir_bit,
   input  logic                            req_fin_bit,
   input  logic                            req_con_bit,
   input  logic [SEQ_BITS-1:0]             req_seq_in,
   input  logic [acf_pkg::LIMIT_W-1:0]     req_retry_limit,
   input  logic                            advance,
   output logic                            hold_valid,
   output logic [acf_pkg::OPCODE_W-1:0]    hold_opcode,
   output logic [acf_pkg::FUNC_W-1:0]      hold_function_code,
   output logic                            hold_fir_bit,
   output logic                            hold_fin_bit,
   output logic                            hold_con_bit,
   output logic [SEQ_BITS-1:0]             hold_seq_in,
   output logic [acf_pkg::LIMIT_W-1:0]     hold_retry_limit
);
   import acf_pkg::*;

   logic                valid_ff, valid_in;
   logic [OPCODE_W-1:0] opcode_ff;
   logic [FUNC_W-1:0]   func_ff;
   logic                fir_ff, fin_ff, con_ff;
   logic [SEQ_BITS-1:0] seq_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                load;

   // Take a new request when empty or when the held one leaves this cycle
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload; no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         opcode_ff <= req_opcode;
         func_ff   <= req_function_code;
         fir_ff    <= req_fir_bit;
         fin_ff    <= req_fin_bit;
         con_ff    <= req_con_bit;
         seq_ff    <= req_seq_in;
         limit_ff  <= req_retry_limit;
      end
   end

   assign hold_valid         = valid_ff;
   assign hold_opcode        = opcode_ff;
   assign hold_function_code = func_ff;
   assign hold_fir_bit       = fir_ff;
   assign hold_fin_bit       = fin_ff;
   assign hold_con_bit       = con_ff;
   assign hold_seq_in        = seq_ff;
   assign hold_retry_limit   = limit_ff;

endmodule

// ===== rtl/core/acf_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acf_step: channel transition logic
// Given the held request and the current channel registers, works out the
// next state, the sequence and retry updates, and the result fields.
// ----------------------------------------------------------------------------
module acf_step #(
   parameter int SEQ_BITS   = 4,
   parameter int RETRY_BITS = 8
) (
   input  logic [acf_pkg::OPCODE_W-1:0]   opcode,
   input  logic [acf_pkg::FUNC_W-1:0]     function_code,
   input  logic                           fir_bit,
   input  logic                           fin_bit,
   input  logic                           con_bit,
   input  logic [SEQ_BITS-1:0]            seq_in,
   input  logic [acf_pkg::LIMIT_W-1:0]    retry_limit,
   input  acf_pkg::chan_state_type        state_cur,
   input  logic [SEQ_BITS-1:0]            seq_cur,
   input  logic                           seq_valid_cur,
   input  logic [RETRY_BITS-1:0]          retries_cur,
   output acf_pkg::chan_state_type        state_next,
   output logic [SEQ_BITS-1:0]            seq_next,
   output logic                           seq_valid_next,
   output logic [RETRY_BITS-1:0]          retries_next,
   output acf_pkg::action_type            action,
   output acf_pkg::timer_type             timer_cmd,
   output acf_pkg::status_type            status
);
   import acf_pkg::*;

   localparam int CMP_W = (RETRY_BITS > LIMIT_W) ? RETRY_BITS : LIMIT_W;
   localparam logic [CMP_W-1:0] RETRY_MAX = CMP_W'((64'd1 << RETRY_BITS) - 64'd1);

   opcode_type          op;
   logic                sending;
   logic                send_bump;
   logic [SEQ_BITS-1:0] seq_bumped;
   logic [SEQ_BITS-1:0] send_seq;
   logic                send_seq_valid;
   logic                is_resp_fc;
   logic                is_unsol_fc;
   logic                send_refused;
   logic [CMP_W-1:0]    limit_ext;
   logic [RETRY_BITS-1:0] retry_load;
   logic                seq_match;
   logic                expect_fir;
   logic                resp_ok;
   logic                have_retry;

   assign op      = opcode_type'(opcode);
   assign sending = (state_cur == ST_SEND) || (state_cur == ST_SEND_CONF) ||
                    (state_cur == ST_SEND_EXP);

   // Sequence advance: from unset it lands on zero
   assign seq_bumped = seq_valid_cur ? (seq_cur + SEQ_BITS'(1)) : '0;

   // A first-fragment response keeps the sequence; any other send advances it
   assign is_resp_fc     = (function_code == FC_RESPONSE);
   assign is_unsol_fc    = (function_code == FC_UNSOLICITED);
   assign send_bump      = !(fir_bit && is_resp_fc);
   assign send_seq       = send_bump ? seq_bumped : seq_cur;
   assign send_seq_valid = send_bump || seq_valid_cur;
   assign send_refused   = (function_code == FC_CONFIRM) ||
                           (is_resp_fc && !send_seq_valid);

   // Saturate the retry budget to the counter width
   assign limit_ext  = CMP_W'(retry_limit);
   assign retry_load = (limit_ext > RETRY_MAX) ? RETRY_BITS'(RETRY_MAX)
                                               : RETRY_BITS'(limit_ext);

   // Response and confirm checks
   assign seq_match  = seq_valid_cur && (seq_in == seq_cur);
   assign expect_fir = (state_cur == ST_WAIT_FIRST);
   assign resp_ok    = seq_match && (fir_bit == expect_fir);
   assign have_retry = (retries_cur != '0);

   // Next channel state
   always_comb begin
      state_next = state_cur;
      unique case (op)
         OP_SEND: begin
            if (state_cur == ST_IDLE && !send_refused) begin
               if (is_resp_fc || is_unsol_fc) begin
                  state_next = con_bit ? ST_SEND_CONF : ST_SEND;
               end else if (function_code == FC_DIR_OP_NACK) begin
                  state_next = ST_SEND;
               end else begin
                  state_next = ST_SEND_EXP;
               end
            end
         end
         OP_CANCEL: begin
            if (sending || state_cur == ST_SEND_CANC) begin
               state_next = ST_SEND_CANC;
            end else if (state_cur == ST_WAIT_CONF) begin
               state_next = ST_IDLE;
            end
         end
         OP_SEND_OK: begin
            unique case (state_cur)
               ST_SEND, ST_SEND_CANC: state_next = ST_IDLE;
               ST_SEND_CONF:          state_next = ST_WAIT_CONF;
               ST_SEND_EXP:           state_next = ST_WAIT_FIRST;
               default:               state_next = state_cur;
            endcase
         end
         OP_SEND_ERR: begin
            if (sending) begin
               state_next = have_retry ? state_cur : ST_IDLE;
            end else if (state_cur == ST_SEND_CANC) begin
               state_next = ST_IDLE;
            end
         end
         OP_CONFIRM: begin
            if (state_cur == ST_WAIT_CONF && seq_match) begin
               state_next = ST_IDLE;
            end
         end
         OP_RESPONSE: begin
            if ((state_cur == ST_WAIT_FIRST || state_cur == ST_WAIT_FINAL) && resp_ok) begin
               state_next = fin_bit ? ST_IDLE : ST_WAIT_FINAL;
            end
         end
         OP_TIMEOUT: begin
            if (state_cur == ST_WAIT_CONF) begin
               state_next = have_retry ? ST_SEND_CONF : ST_IDLE;
            end else if (state_cur == ST_WAIT_FIRST || state_cur == ST_WAIT_FINAL) begin
               state_next = have_retry ? ST_SEND_EXP : ST_IDLE;
            end
         end
         OP_SET_SEQ: begin
            state_next = state_cur;
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

   // Result fields and register updates
   always_comb begin
      action         = ACT_NONE;
      timer_cmd      = TMR_NONE;
      status         = STS_OK;
      seq_next       = seq_cur;
      seq_valid_next = seq_valid_cur;
      retries_next   = retries_cur;
      unique case (op)
         OP_SEND: begin
            if (state_cur == ST_IDLE) begin
               seq_next       = send_seq;
               seq_valid_next = send_seq_valid;
               if (function_code == FC_CONFIRM) begin
                  status = STS_MANUAL_CONF;
                  action = ACT_FAIL;
               end else if (is_resp_fc && !send_seq_valid) begin
                  status = STS_NO_REQ;
                  action = ACT_FAIL;
               end else begin
                  action       = ACT_QUEUE;
                  retries_next = retry_load;
                  if (con_bit && !is_resp_fc && !is_unsol_fc) begin
                     status = STS_CON_IGN;
                  end
               end
            end else begin
               status = STS_INVALID;
            end
         end
         OP_CANCEL: begin
            if (state_cur == ST_WAIT_CONF) begin
               timer_cmd = TMR_CANCEL;
               action    = ACT_FAIL;
            end else if (!sending && state_cur != ST_SEND_CANC) begin
               status = STS_INVALID;
            end
         end
         OP_SEND_OK: begin
            unique case (state_cur)
               ST_SEND:                   action    = ACT_SUCCESS;
               ST_SEND_CANC:              action    = ACT_FAIL;
               ST_SEND_CONF, ST_SEND_EXP: timer_cmd = TMR_START;
               default:                   status    = STS_INVALID;
            endcase
         end
         OP_SEND_ERR: begin
            if (sending) begin
               if (have_retry) begin
                  retries_next = retries_cur - RETRY_BITS'(1);
                  action       = ACT_RESEND;
               end else begin
                  action = ACT_FAIL;
               end
            end else if (state_cur == ST_SEND_CANC) begin
               action = ACT_FAIL;
            end else begin
               status = STS_INVALID;
            end
         end
         OP_CONFIRM: begin
            if (state_cur != ST_WAIT_CONF) begin
               status = STS_INVALID;
            end else if (seq_match) begin
               timer_cmd = TMR_CANCEL;
               action    = ACT_SUCCESS;
            end else begin
               status = STS_UNEXP_CONF;
            end
         end
         OP_RESPONSE: begin
            if (state_cur == ST_WAIT_FIRST || state_cur == ST_WAIT_FINAL) begin
               if (!seq_match) begin
                  status = STS_BAD_SEQ;
               end else if (fir_bit != expect_fir) begin
                  status = STS_BAD_FIR;
               end else if (fin_bit) begin
                  timer_cmd = TMR_CANCEL;
                  action    = ACT_FINAL;
               end else begin
                  seq_next       = seq_bumped;
                  seq_valid_next = 1'b1;
                  timer_cmd      = TMR_START;
                  action         = ACT_PARTIAL;
               end
            end else begin
               status = STS_INVALID;
            end
         end
         OP_TIMEOUT: begin
            if (state_cur == ST_WAIT_CONF || state_cur == ST_WAIT_FIRST ||
                state_cur == ST_WAIT_FINAL) begin
               status = STS_TIMEOUT;
               if (have_retry) begin
                  retries_next = retries_cur - RETRY_BITS'(1);
                  action       = ACT_RESEND;
               end else begin
                  action = ACT_FAIL;
               end
            end else begin
               status = STS_INVALID;
            end
         end
         OP_SET_SEQ: begin
            seq_next       = seq_in;
            seq_valid_next = 1'b1;
         end
         default: begin
            status = STS_OK;
         end
      endcase
   end

endmodule

// ===== rtl/core/app_channel_transaction_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// app_channel_transaction_fsm: application transaction channel
// Eight-state channel that takes send, cancel, link, confirm, response,
// timeout and set-sequence events and returns one result per event.
// ----------------------------------------------------------------------------
//  Channel    | Direction | Handshake           | Payload
//  -----------+-----------+---------------------+-------------------------------
//  req_       | in        | req_valid/req_ready | opcode, function code, fir, fin,
//             |           |                     | con, sequence, retry limit
//  rsp_       | out       | rsp_valid/rsp_ready | action, timer, sequence,
//             |           |                     | status, state
//
//  One request per cycle sustained while rsp_ready stays high; an accepted
//  request passes through the input register, then the transition logic into
//  the result register, where rsp_valid rises.
//  The channel registers update when the held request moves into the result
//  register, so each request sees the effect of the one before it.
//  A stalled result holds the input register; req_ready drops only when both
//  the input register and the result register are full.
//  Synchronous reset returns the channel to idle with the sequence unset.
// ----------------------------------------------------------------------------
module app_channel_transaction_fsm #(
   parameter int SEQ_BITS   = 4,
   parameter int RETRY_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [acf_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [acf_pkg::FUNC_W-1:0]    req_function_code,
   input  logic                          req_fir_bit,
   input  logic                          req_fin_bit,
   input  logic                          req_con_bit,
   input  logic [SEQ_BITS-1:0]           req_seq_in,
   input  logic [acf_pkg::LIMIT_W-1:0]   req_retry_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [acf_pkg::ACTION_W-1:0]  rsp_action,
   output logic [acf_pkg::TIMER_W-1:0]   rsp_timer_cmd,
   output logic [SEQ_BITS-1:0]           rsp_seq_out,
   output logic [acf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [acf_pkg::STATE_W-1:0]   rsp_state_out
);
   import acf_pkg::*;

   // Held request
   logic                hold_valid;
   logic [OPCODE_W-1:0] hold_opcode;
   logic [FUNC_W-1:0]   hold_function_code;
   logic                hold_fir_bit, hold_fin_bit, hold_con_bit;
   logic [SEQ_BITS-1:0] hold_seq_in;
   logic [LIMIT_W-1:0]  hold_retry_limit;
   logic                advance;

   // Channel registers
   chan_state_type        state_ff, state_in;
   logic [SEQ_BITS-1:0]   seq_ff, seq_in;
   logic                  seq_valid_ff, seq_valid_in;
   logic [RETRY_BITS-1:0] retries_ff, retries_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          action_ff, action_in;
   timer_type           timer_ff, timer_in;
   logic [SEQ_BITS-1:0] seq_out_ff;
   status_type          status_ff, status_in;
   chan_state_type      state_out_ff;

   // Move the held request forward when the result register is free
   assign advance = hold_valid && (!rsp_valid_ff || rsp_ready);

   acf_in_reg #(
      .SEQ_BITS (SEQ_BITS)
   ) u_in_reg (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_function_code  (req_function_code),
      .req_fir_bit        (req_fir_bit),
      .req_fin_bit        (req_fin_bit),
      .req_con_bit        (req_con_bit),
      .req_seq_in         (req_seq_in),
      .req_retry_limit    (req_retry_limit),
      .advance            (advance),
      .hold_valid         (hold_valid),
      .hold_opcode        (hold_opcode),
      .hold_function_code (hold_function_code),
      .hold_fir_bit       (hold_fir_bit),
      .hold_fin_bit       (hold_fin_bit),
      .hold_con_bit       (hold_con_bit),
      .hold_seq_in        (hold_seq_in),
      .hold_retry_limit   (hold_retry_limit)
   );

   acf_step #(
      .SEQ_BITS   (SEQ_BITS),
      .RETRY_BITS (RETRY_BITS)
   ) u_step (
      .opcode         (hold_opcode),
      .function_code  (hold_function_code),
      .fir_bit        (hold_fir_bit),
      .fin_bit        (hold_fin_bit),
      .con_bit        (hold_con_bit),
      .seq_in         (hold_seq_in),
      .retry_limit    (hold_retry_limit),
      .state_cur      (state_ff),
      .seq_cur        (seq_ff),
      .seq_valid_cur  (seq_valid_ff),
      .retries_cur    (retries_ff),
      .state_next     (state_in),
      .seq_next       (seq_in),
      .seq_valid_next (seq_valid_in),
      .retries_next   (retries_in),
      .action         (action_in),
      .timer_cmd      (timer_in),
      .status         (status_in)
   );

   // Result valid: set on advance, drop when taken
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Update channel registers and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         seq_valid_ff <= 1'b0;
         retries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff     <= state_in;
            seq_ff       <= seq_in;
            seq_valid_ff <= seq_valid_in;
            retries_ff   <= retries_in;
         end
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff    <= action_in;
         timer_ff     <= timer_in;
         status_ff    <= status_in;
         state_out_ff <= state_in;
         seq_out_ff   <= seq_valid_in ? seq_in : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = action_ff;
   assign rsp_timer_cmd = timer_ff;
   assign rsp_seq_out   = seq_out_ff;
   assign rsp_status    = status_ff;
   assign rsp_state_out = state_out_ff;

   // Channel registers move only with a request
   a_regs_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(state_ff) && $stable(seq_ff) &&
                    $stable(seq_valid_ff) && $stable(retries_ff)))
      else $error("channel registers changed without a request");

   // An unset sequence stays at zero
   a_unset_zero : assert property (@(posedge clock) disable iff (reset)
      !seq_valid_ff |-> (seq_ff == '0))
      else $error("unset sequence is not zero");

   // Every advanced request produces a result
   a_adv_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request advanced without a result");

   // A final response always closes the channel
   a_final_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_FINAL) |-> (rsp_state_out == ST_IDLE))
      else $error("final response left channel open");

   // Back-pressure only when both stages are full
   a_ready_low : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (hold_valid && rsp_valid_ff))
      else $error("request refused with a free stage");

endmodule

// ===== tb/sv/chan_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chan_result_checker: result predictor and scoreboard for the channel FSM
// Watches the request and response channels. Every accepted request runs
// through a local copy of the channel state machine; the predicted result is
// queued and compared field by field with the next accepted response.
// ----------------------------------------------------------------------------
module chan_result_checker #(
   parameter int SEQ_BITS   = 4,
   parameter int RETRY_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [acf_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [acf_pkg::FUNC_W-1:0]    req_function_code,
   input  logic                          req_fir_bit,
   input  logic                          req_fin_bit,
   input  logic                          req_con_bit,
   input  logic [SEQ_BITS-1:0]           req_seq_in,
   input  logic [acf_pkg::LIMIT_W-1:0]   req_retry_limit,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [acf_pkg::ACTION_W-1:0]  rsp_action,
   input  logic [acf_pkg::TIMER_W-1:0]   rsp_timer_cmd,
   input  logic [SEQ_BITS-1:0]           rsp_seq_out,
   input  logic [acf_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [acf_pkg::STATE_W-1:0]   rsp_state_out,
   output int                            fail_count,
   output int                            pending
);
   import acf_pkg::*;

   localparam longint RETRY_MAX = (64'd1 << RETRY_BITS) - 1;

   typedef struct packed {
      action_type          action;
      timer_type           timer;
      logic [SEQ_BITS-1:0] seq;
      status_type          status;
      chan_state_type      state;
   } chan_result_type;

   // Local copy of the channel registers
   chan_state_type        chan_q;
   logic [SEQ_BITS-1:0]   seq_q;
   logic                  seq_set;
   logic [RETRY_BITS-1:0] retries_q;

   chan_result_type expected_results[$];
   int              mismatch_count = 0;
   int              waiting_cnt = 0;

   assign fail_count = mismatch_count;
   assign pending    = waiting_cnt;

   // Advance the sequence, or start it at zero when still unset
   function automatic void advance_seq();
      if (seq_set) seq_q = seq_q + SEQ_BITS'(1);
      else seq_q = '0;
      seq_set = 1'b1;
   endfunction

   function automatic logic seq_hit(input logic [SEQ_BITS-1:0] sq);
      return seq_set && (sq == seq_q);
   endfunction

   // Spend one retry and go back to a send state, or drop to idle
   function automatic action_type take_retry(input chan_state_type back_to);
      if (retries_q != '0) begin
         retries_q = retries_q - RETRY_BITS'(1);
         chan_q = back_to;
         return ACT_RESEND;
      end
      chan_q = ST_IDLE;
      return ACT_FAIL;
   endfunction

   // Apply one request to the local channel and return its result
   function automatic chan_result_type predict_event(
      input opcode_type                op,
      input logic [FUNC_W-1:0]         fc,
      input logic                      fir,
      input logic                      fin,
      input logic                      con,
      input logic [SEQ_BITS-1:0]       sq,
      input logic [LIMIT_W-1:0]        lim
   );
      chan_result_type res;
      chan_state_type  cur;
      logic            sending;
      logic            expect_fir;
      cur = chan_q;
      sending = (cur == ST_SEND) || (cur == ST_SEND_CONF) || (cur == ST_SEND_EXP);
      res.action = ACT_NONE;
      res.timer  = TMR_NONE;
      res.status = STS_OK;
      case (op)
         OP_SEND: begin
            if (cur != ST_IDLE) begin
               res.status = STS_INVALID;
            end else begin
               // a first-fragment response reuses the current sequence
               if (!(fir && fc == FC_RESPONSE)) advance_seq();
               if (fc == FC_CONFIRM) begin
                  res.status = STS_MANUAL_CONF;
                  res.action = ACT_FAIL;
               end else if (fc == FC_RESPONSE && !seq_set) begin
                  res.status = STS_NO_REQ;
                  res.action = ACT_FAIL;
               end else begin
                  if (fc == FC_RESPONSE || fc == FC_UNSOLICITED) begin
                     chan_q = con ? ST_SEND_CONF : ST_SEND;
                  end else begin
                     if (con) res.status = STS_CON_IGN;
                     chan_q = (fc == FC_DIR_OP_NACK) ? ST_SEND : ST_SEND_EXP;
                  end
                  if (longint'(lim) > RETRY_MAX) retries_q = RETRY_BITS'(RETRY_MAX);
                  else retries_q = RETRY_BITS'(lim);
                  res.action = ACT_QUEUE;
               end
            end
         end
         OP_CANCEL: begin
            if (sending || cur == ST_SEND_CANC) begin
               chan_q = ST_SEND_CANC;
            end else if (cur == ST_WAIT_CONF) begin
               chan_q = ST_IDLE;
               res.timer  = TMR_CANCEL;
               res.action = ACT_FAIL;
            end else begin
               res.status = STS_INVALID;
            end
         end
         OP_SEND_OK: begin
            case (cur)
               ST_SEND: begin
                  chan_q = ST_IDLE;
                  res.action = ACT_SUCCESS;
               end
               ST_SEND_CONF: begin
                  chan_q = ST_WAIT_CONF;
                  res.timer = TMR_START;
               end
               ST_SEND_EXP: begin
                  chan_q = ST_WAIT_FIRST;
                  res.timer = TMR_START;
               end
               ST_SEND_CANC: begin
                  chan_q = ST_IDLE;
                  res.action = ACT_FAIL;
               end
               default: res.status = STS_INVALID;
            endcase
         end
         OP_SEND_ERR: begin
            if (sending) begin
               res.action = take_retry(cur);
            end else if (cur == ST_SEND_CANC) begin
               chan_q = ST_IDLE;
               res.action = ACT_FAIL;
            end else begin
               res.status = STS_INVALID;
            end
         end
         OP_CONFIRM: begin
            if (cur != ST_WAIT_CONF) begin
               res.status = STS_INVALID;
            end else if (seq_hit(sq)) begin
               chan_q = ST_IDLE;
               res.timer  = TMR_CANCEL;
               res.action = ACT_SUCCESS;
            end else begin
               res.status = STS_UNEXP_CONF;
            end
         end
         OP_RESPONSE: begin
            if (cur == ST_WAIT_FIRST || cur == ST_WAIT_FINAL) begin
               expect_fir = (cur == ST_WAIT_FIRST);
               if (!seq_hit(sq)) begin
                  res.status = STS_BAD_SEQ;
               end else if (fir != expect_fir) begin
                  res.status = STS_BAD_FIR;
               end else if (fin) begin
                  chan_q = ST_IDLE;
                  res.timer  = TMR_CANCEL;
                  res.action = ACT_FINAL;
               end else begin
                  advance_seq();
                  chan_q = ST_WAIT_FINAL;
                  res.timer  = TMR_START;
                  res.action = ACT_PARTIAL;
               end
            end else begin
               res.status = STS_INVALID;
            end
         end
         OP_TIMEOUT: begin
            if (cur == ST_WAIT_CONF) begin
               res.status = STS_TIMEOUT;
               res.action = take_retry(ST_SEND_CONF);
            end else if (cur == ST_WAIT_FIRST || cur == ST_WAIT_FINAL) begin
               res.status = STS_TIMEOUT;
               res.action = take_retry(ST_SEND_EXP);
            end else begin
               res.status = STS_INVALID;
            end
         end
         default: begin
            // load the sequence in any state
            seq_q = sq;
            seq_set = 1'b1;
         end
      endcase
      res.seq   = seq_set ? seq_q : '0;
      res.state = chan_q;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // Compare each response, then queue the prediction for each request
   always @(posedge clock) begin
      chan_result_type want;
      if (reset) begin
         chan_q    = ST_IDLE;
         seq_q     = '0;
         seq_set   = 1'b0;
         retries_q = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: action %0d, state %0d",
                      rsp_action, rsp_state_out);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("action", 8'(want.action), 8'(rsp_action));
               check_field("timer_cmd", 8'(want.timer), 8'(rsp_timer_cmd));
               check_field("seq_out", 8'(want.seq), 8'(rsp_seq_out));
               check_field("status", 8'(want.status), 8'(rsp_status));
               check_field("state_out", 8'(want.state), 8'(rsp_state_out));
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_event(opcode_type'(req_opcode),
               req_function_code, req_fir_bit, req_fin_bit, req_con_bit,
               req_seq_in, req_retry_limit));
         end
      end
      waiting_cnt <= expected_results.size();
   end

endmodule

// ===== tb/sv/app_channel_transaction_fsm_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// app_channel_transaction_fsm_tb: top level bench for the transaction channel
// Drives a directed opening and then random transactions (request/response,
// confirmed send, plain send, refused send, noise) with random idling on both
// channels and one long response stall. A checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module app_channel_transaction_fsm_tb;
   import acf_pkg::*;

   localparam int SEQ_BITS    = 4;
   localparam int RETRY_BITS  = 8;
   localparam int TOTAL_REQS  = 1400;
   localparam int CALM_AFTER  = 1250;
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 400;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OPCODE_W-1:0]  req_opcode = '0;
   logic [FUNC_W-1:0]    req_function_code = '0;
   logic                 req_fir_bit = 1'b0;
   logic                 req_fin_bit = 1'b0;
   logic                 req_con_bit = 1'b0;
   logic [SEQ_BITS-1:0]  req_seq_in = '0;
   logic [LIMIT_W-1:0]   req_retry_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ACTION_W-1:0]  rsp_action;
   logic [TIMER_W-1:0]   rsp_timer_cmd;
   logic [SEQ_BITS-1:0]  rsp_seq_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [STATE_W-1:0]   rsp_state_out;

   int fail_count;
   int pending;
   int req_count = 0;
   bit calm = 1'b0;

   app_channel_transaction_fsm #(
      .SEQ_BITS   (SEQ_BITS),
      .RETRY_BITS (RETRY_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_function_code (req_function_code),
      .req_fir_bit       (req_fir_bit),
      .req_fin_bit       (req_fin_bit),
      .req_con_bit       (req_con_bit),
      .req_seq_in        (req_seq_in),
      .req_retry_limit   (req_retry_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_timer_cmd     (rsp_timer_cmd),
      .rsp_seq_out       (rsp_seq_out),
      .rsp_status        (rsp_status),
      .rsp_state_out     (rsp_state_out)
   );

   chan_result_checker #(
      .SEQ_BITS   (SEQ_BITS),
      .RETRY_BITS (RETRY_BITS)
   ) result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_function_code (req_function_code),
      .req_fir_bit       (req_fir_bit),
      .req_fin_bit       (req_fin_bit),
      .req_con_bit       (req_con_bit),
      .req_seq_in        (req_seq_in),
      .req_retry_limit   (req_retry_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_action        (rsp_action),
      .rsp_timer_cmd     (rsp_timer_cmd),
      .rsp_seq_out       (rsp_seq_out),
      .rsp_status        (rsp_status),
      .rsp_state_out     (rsp_state_out),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   function automatic logic any_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [SEQ_BITS-1:0] any_seq();
      return SEQ_BITS'($urandom_range(0, (1 << SEQ_BITS) - 1));
   endfunction

   function automatic logic [SEQ_BITS-1:0] other_seq(input logic [SEQ_BITS-1:0] sq);
      return sq + SEQ_BITS'($urandom_range(1, (1 << SEQ_BITS) - 1));
   endfunction

   // Mostly small retry budgets, now and then any value
   function automatic logic [7:0] any_limit();
      if ($urandom_range(0, 9) == 0) return any_byte();
      return 8'($urandom_range(0, 3));
   endfunction

   // Offer one request, hold it until accepted, then maybe idle
   task automatic issue(input opcode_type op, input logic [7:0] fc, input logic fir,
                        input logic fin, input logic con, input logic [SEQ_BITS-1:0] sq,
                        input logic [7:0] lim);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_function_code <= fc;
      req_fir_bit       <= fir;
      req_fin_bit       <= fin;
      req_con_bit       <= con;
      req_seq_in        <= sq;
      req_retry_limit   <= lim;
      do @(posedge clock); while (!req_ready);
      req_count++;
      calm = (req_count >= CALM_AFTER);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Request whose other fields do not matter
   task automatic pulse(input opcode_type op, input logic [SEQ_BITS-1:0] sq);
      issue(op, any_byte(), any_bit(), any_bit(), any_bit(), sq, any_byte());
   endtask

   // Timeout, cancel, link failure: lands in idle from any state
   task automatic drain_to_idle();
      pulse(OP_TIMEOUT, any_seq());
      pulse(OP_CANCEL, any_seq());
      pulse(OP_SEND_ERR, any_seq());
   endtask

   // Fail the link a few times; report when the budget ran out
   task automatic link_failures(inout int left, output bit dropped);
      int n;
      int i;
      dropped = 1'b0;
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
         pulse(OP_SEND_ERR, any_seq());
         if (left == 0) begin
            dropped = 1'b1;
            return;
         end
         left--;
      end
   endtask

   // Cancel while sending, then let the link report either way
   task automatic cancel_in_flight();
      pulse(OP_CANCEL, any_seq());
      if (any_bit()) pulse(OP_CANCEL, any_seq());
      pulse(any_bit() ? OP_SEND_OK : OP_SEND_ERR, any_seq());
   endtask

   // Request that expects a response, possibly in several fragments
   task automatic run_request_response();
      logic [SEQ_BITS-1:0] cs;
      logic [7:0]          fc;
      logic [7:0]          lim;
      int                  left;
      bit                  dropped;
      int                  nresp;
      int                  i;
      logic                first;
      logic                last;
      drain_to_idle();
      cs = any_seq();
      pulse(OP_SET_SEQ, cs);
      cs = cs + SEQ_BITS'(1);
      do fc = any_byte();
      while (fc == FC_CONFIRM || fc == FC_DIR_OP_NACK || fc == FC_RESPONSE ||
             fc == FC_UNSOLICITED);
      lim = any_limit();
      issue(OP_SEND, fc, any_bit(), any_bit(), any_bit(), any_seq(), lim);
      left = int'(lim);
      link_failures(left, dropped);
      if (dropped) return;
      if ($urandom_range(0, 7) == 0) begin
         cancel_in_flight();
         return;
      end
      pulse(OP_SEND_OK, any_seq());
      if ($urandom_range(0, 3) == 0) begin
         pulse(OP_TIMEOUT, any_seq());
         if (left == 0) return;
         left--;
         pulse(OP_SEND_OK, any_seq());
      end
      first = 1'b1;
      nresp = $urandom_range(1, 4);
      for (i = 0; i < nresp; i++) begin
         last = (i == nresp - 1);
         // slip in a wrong sequence or a wrong first-fragment bit
         if ($urandom_range(0, 7) == 0)
            issue(OP_RESPONSE, any_byte(), first, last, any_bit(), other_seq(cs),
                  any_byte());
         else if ($urandom_range(0, 7) == 0)
            issue(OP_RESPONSE, any_byte(), !first, last, any_bit(), cs, any_byte());
         issue(OP_RESPONSE, any_byte(), first, last, any_bit(), cs, any_byte());
         if (!last) begin
            cs = cs + SEQ_BITS'(1);
            first = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
               pulse(OP_TIMEOUT, any_seq());
               if (left == 0) return;
               left--;
               pulse(OP_SEND_OK, any_seq());
               first = 1'b1;
            end
         end
      end
   endtask

   // Response or unsolicited send that waits for a confirm
   task automatic run_confirmed_send();
      logic [SEQ_BITS-1:0] cs;
      logic [7:0]          fc;
      logic [7:0]          lim;
      logic                fir;
      int                  left;
      bit                  dropped;
      int                  i;
      drain_to_idle();
      cs = any_seq();
      pulse(OP_SET_SEQ, cs);
      fc = any_bit() ? FC_RESPONSE : FC_UNSOLICITED;
      fir = any_bit();
      if (!(fir && fc == FC_RESPONSE)) cs = cs + SEQ_BITS'(1);
      lim = any_limit();
      issue(OP_SEND, fc, fir, any_bit(), 1'b1, any_seq(), lim);
      left = int'(lim);
      link_failures(left, dropped);
      if (dropped) return;
      if ($urandom_range(0, 7) == 0) begin
         cancel_in_flight();
         return;
      end
      pulse(OP_SEND_OK, any_seq());
      for (i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0: begin
               pulse(OP_TIMEOUT, any_seq());
               if (left == 0) return;
               left--;
               pulse(OP_SEND_OK, any_seq());
            end
            1: pulse(OP_CONFIRM, other_seq(cs));
            2: begin
               pulse(OP_CANCEL, any_seq());
               return;
            end
            default: begin
               pulse(OP_CONFIRM, cs);
               return;
            end
         endcase
      end
      pulse(OP_CONFIRM, cs);
   endtask

   // Send that needs only the link to succeed
   task automatic run_plain_send();
      logic [7:0] fc;
      logic [7:0] lim;
      logic       con;
      int         left;
      bit         dropped;
      drain_to_idle();
      pulse(OP_SET_SEQ, any_seq());
      case ($urandom_range(0, 2))
         0: begin
            fc = FC_DIR_OP_NACK;
            con = any_bit();
         end
         1: begin
            fc = FC_RESPONSE;
            con = 1'b0;
         end
         default: begin
            fc = FC_UNSOLICITED;
            con = 1'b0;
         end
      endcase
      lim = any_limit();
      issue(OP_SEND, fc, any_bit(), any_bit(), con, any_seq(), lim);
      left = int'(lim);
      link_failures(left, dropped);
      if (dropped) return;
      if ($urandom_range(0, 3) == 0) cancel_in_flight();
      else pulse(OP_SEND_OK, any_seq());
   endtask

   // Send of a confirm or of any function, followed by stray events
   task automatic run_odd_send();
      int n;
      drain_to_idle();
      issue(OP_SEND, any_bit() ? FC_CONFIRM : any_byte(), any_bit(), any_bit(),
            any_bit(), any_seq(), any_byte());
      n = $urandom_range(0, 3);
      repeat (n) pulse(opcode_type'($urandom_range(0, 7)), any_seq());
   endtask

   // Release reset, run directed and random requests, then give the verdict
   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening: sequence unset, refusals, retries, every state
      issue(OP_SEND, FC_RESPONSE, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0);
      pulse(OP_CONFIRM, 4'd0);
      issue(OP_SEND, FC_CONFIRM, 1'b0, 1'b0, 1'b1, 4'd0, 8'd3);
      issue(OP_SET_SEQ, 8'hFF, 1'b1, 1'b1, 1'b1, 4'd15, 8'hFF);
      issue(OP_SEND, FC_DIR_OP_NACK, 1'b0, 1'b0, 1'b1, 4'd0, 8'd255);
      pulse(OP_SEND_ERR, 4'd0);
      pulse(OP_SEND_OK, 4'd0);
      issue(OP_SEND, 8'd200, 1'b0, 1'b0, 1'b1, 4'd0, 8'd0);
      pulse(OP_CANCEL, 4'd0);
      pulse(OP_CANCEL, 4'd0);
      pulse(OP_SEND_OK, 4'd0);
      issue(OP_SEND, 8'd255, 1'b0, 1'b1, 1'b0, 4'd15, 8'd1);
      pulse(OP_SEND_OK, 4'd0);
      pulse(OP_TIMEOUT, 4'd0);
      pulse(OP_SEND_OK, 4'd0);
      issue(OP_RESPONSE, 8'd0, 1'b1, 1'b0, 1'b0, 4'd3, 8'd0);
      issue(OP_RESPONSE, 8'd0, 1'b0, 1'b0, 1'b0, 4'd2, 8'd0);
      issue(OP_RESPONSE, 8'd0, 1'b1, 1'b0, 1'b0, 4'd2, 8'd0);
      issue(OP_RESPONSE, 8'd0, 1'b1, 1'b1, 1'b0, 4'd3, 8'd0);
      pulse(OP_TIMEOUT, 4'd0);
      issue(OP_SEND, FC_UNSOLICITED, 1'b0, 1'b0, 1'b1, 4'd0, 8'd0);
      pulse(OP_SEND_OK, 4'd0);
      pulse(OP_CONFIRM, 4'd0);
      pulse(OP_CONFIRM, 4'd4);
      issue(OP_SEND, FC_RESPONSE, 1'b1, 1'b0, 1'b1, 4'd0, 8'd2);

      // random transactions, mostly well formed
      while (req_count < TOTAL_REQS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: run_request_response();
            4, 5:       run_confirmed_send();
            6, 7:       run_plain_send();
            8:          run_odd_send();
            default: begin
               n = $urandom_range(1, 6);
               repeat (n)
                  issue(opcode_type'($urandom_range(0, 7)), any_byte(), any_bit(),
                        any_bit(), any_bit(), any_seq(), any_byte());
            end
         endcase
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then allow the pipeline to settle
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Stall responses in random bursts, once for a long stretch
   initial begin
      int hold;
      bit held_long;
      held_long = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_long && req_count >= HOLD_AFTER) begin
            held_long = 1'b1;
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < HOLD_CYCLES) begin
               @(posedge clock);
               hold++;
            end
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/acf_pkg.sv
rtl/core/acf_in_reg.sv
rtl/core/acf_step.sv
rtl/core/app_channel_transaction_fsm.sv
tb/sv/chan_result_checker.sv
tb/sv/app_channel_transaction_fsm_tb.sv
